>>> src/cfa_pkg.sv
package cfa_pkg;

  localparam int MAX_GROUPS  = 4096;
  localparam int LANES       = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int SUM_BITS    = 32;

  localparam int GI_BITS   = $clog2(MAX_GROUPS);
  localparam int WORD_BITS = 2 * SUM_BITS;
  localparam int GC_BITS   = 13;
  localparam int FC_BITS   = 16;

  localparam logic REG_GROUP_COUNT = 1'b0;
  localparam logic REG_FRAME_COUNT = 1'b1;

  typedef struct packed {
    logic [31:0] sample_0;
    logic [31:0] sample_1;
    logic [31:0] sample_2;
    logic [31:0] sample_3;
    logic [31:0] sample_4;
    logic [31:0] sample_5;
    logic [31:0] sample_6;
    logic [31:0] sample_7;
  } sample_beat_t;

  typedef struct packed {
    logic [63:0] sum_0;
    logic [63:0] sum_1;
    logic [63:0] sum_2;
    logic [63:0] sum_3;
    logic [63:0] sum_4;
    logic [63:0] sum_5;
    logic [63:0] sum_6;
    logic [63:0] sum_7;
    logic        frame_end;
  } sum_beat_t;

  typedef logic [LANES-1:0][WORD_BITS-1:0] row_t;

  typedef struct packed {
    logic [GI_BITS-1:0] gi;
    logic               first_frame;
    logic               last_frame;
    logic               last_group;
  } step_t;

  function automatic logic [31:0] lane_sample(sample_beat_t b, int k);
    logic [31:0] s;
    case (k)
      0: s = b.sample_0;
      1: s = b.sample_1;
      2: s = b.sample_2;
      3: s = b.sample_3;
      4: s = b.sample_4;
      5: s = b.sample_5;
      6: s = b.sample_6;
      7: s = b.sample_7;
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [WORD_BITS-1:0] add_word(logic [WORD_BITS-1:0] old,
                                                    logic [31:0] s);
    logic [SUM_BITS-1:0] re_in;
    logic [SUM_BITS-1:0] im_in;
    logic [SUM_BITS-1:0] re;
    logic [SUM_BITS-1:0] im;
    re_in = {{(SUM_BITS-SAMPLE_BITS){s[2*SAMPLE_BITS-1]}},
             s[2*SAMPLE_BITS-1:SAMPLE_BITS]};
    im_in = {{(SUM_BITS-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s[SAMPLE_BITS-1:0]};
    re = old[WORD_BITS-1:SUM_BITS] + re_in;
    im = old[SUM_BITS-1:0] + im_in;
    return {re, im};
  endfunction

  function automatic sum_beat_t pack_sums(row_t r, logic fe);
    logic [7:0][WORD_BITS-1:0] full;
    sum_beat_t o;
    full = '0;
    for (int k = 0; k < LANES; k++) begin
      full[k] = r[k];
    end
    o.sum_0 = 64'(full[0]);
    o.sum_1 = 64'(full[1]);
    o.sum_2 = 64'(full[2]);
    o.sum_3 = 64'(full[3]);
    o.sum_4 = 64'(full[4]);
    o.sum_5 = 64'(full[5]);
    o.sum_6 = 64'(full[6]);
    o.sum_7 = 64'(full[7]);
    o.frame_end = fe;
    return o;
  endfunction

endpackage

>>> src/complex_frame_accumulator_core.sv
// Coherent frame averager for complex sample groups.
// Sample channel: samples carries eight 32-bit lanes (real high 16, imag low
// 16); a beat moves on a clock edge with sample_valid high and sample_stall low.
// A frame is group_count beats; frame_count frames are summed per lane into a
// 4096-row store, one row per group, read as a beat is taken and written back.
// Sum channel: sums carries eight 64-bit lane sums and frame_end; a beat is
// taken with sum_valid high and sum_stall low. Only the last frame of a run
// produces beats, frame_end marking its final group.
// Throughput is one beat per cycle unless the last-frame stage is held: one
// store read and one write per cycle, with a bypass register covering a row
// read while it is being written back. Sums are registered from the beat stage.
// When the sum side stalls with a result held, the last-frame stage holds and
// sample_stall rises; earlier frames keep flowing while nothing waits.
// Registers on the APB port: group_count at 0x0, frame_count at 0x4, both
// reset to 1; write only while idle. Reset clears the group and frame
// positions and both valids; store contents are left as they are, the first
// frame of a run ignoring them.
module complex_frame_accumulator_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  cfa_pkg::sample_beat_t samples,
  output logic                  sum_valid,
  input  logic                  sum_stall,
  output cfa_pkg::sum_beat_t    sums
);

  logic [cfa_pkg::GC_BITS-1:0] group_count;
  logic [cfa_pkg::FC_BITS-1:0] frame_count;
  logic                        accept;
  logic                        advance;
  cfa_pkg::step_t              step;

  assign pready       = 1'b1;
  assign sample_stall = rst || !advance;
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= cfa_pkg::GC_BITS'(1);
      frame_count <= cfa_pkg::FC_BITS'(1);
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        cfa_pkg::REG_GROUP_COUNT: group_count <= pwdata[cfa_pkg::GC_BITS-1:0];
        cfa_pkg::REG_FRAME_COUNT: frame_count <= pwdata[cfa_pkg::FC_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      cfa_pkg::REG_GROUP_COUNT: prdata = 32'(group_count);
      cfa_pkg::REG_FRAME_COUNT: prdata = 32'(frame_count);
      default:                  prdata = '0;
    endcase
  end

  cfa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .group_count (group_count),
    .frame_count (frame_count),
    .step        (step)
  );

  cfa_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .step      (step),
    .samples   (samples),
    .advance   (advance),
    .sum_valid (sum_valid),
    .sum_stall (sum_stall),
    .sums      (sums)
  );

endmodule

>>> src/cfa_ram.sv
module cfa_ram #(
  parameter int WIDTH = 512,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/cfa_ctrl.sv
module cfa_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [cfa_pkg::GC_BITS-1:0] group_count,
  input  logic [cfa_pkg::FC_BITS-1:0] frame_count,
  output cfa_pkg::step_t              step
);

  logic [cfa_pkg::GI_BITS-1:0] group_index;
  logic [cfa_pkg::FC_BITS-1:0] frame_index;
  logic [cfa_pkg::GC_BITS-1:0] groups;
  logic [cfa_pkg::FC_BITS-1:0] frames;

  always_comb begin
    if (group_count == '0) begin
      groups = cfa_pkg::GC_BITS'(1);
    end else if (group_count > cfa_pkg::GC_BITS'(cfa_pkg::MAX_GROUPS)) begin
      groups = cfa_pkg::GC_BITS'(cfa_pkg::MAX_GROUPS);
    end else begin
      groups = group_count;
    end
    frames = (frame_count == '0) ? cfa_pkg::FC_BITS'(1) : frame_count;

    step.gi          = group_index;
    step.first_frame = (frame_index == '0);
    step.last_frame  = ((17'(frame_index) + 17'd1) >= 17'(frames));
    step.last_group  = ((cfa_pkg::GC_BITS'(group_index) + cfa_pkg::GC_BITS'(1)) >= groups);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_index <= '0;
      frame_index <= '0;
    end else if (accept) begin
      if (step.last_group) begin
        group_index <= '0;
        frame_index <= step.last_frame ? '0 : frame_index + cfa_pkg::FC_BITS'(1);
      end else begin
        group_index <= group_index + cfa_pkg::GI_BITS'(1);
      end
    end
  end

endmodule

>>> src/cfa_accum.sv
module cfa_accum (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  cfa_pkg::step_t        step,
  input  cfa_pkg::sample_beat_t samples,
  output logic                  advance,
  output logic                  sum_valid,
  input  logic                  sum_stall,
  output cfa_pkg::sum_beat_t    sums
);

  logic                  s1_valid;
  cfa_pkg::step_t        s1_step;
  cfa_pkg::sample_beat_t s1_samples;
  logic                  s1_fwd;
  cfa_pkg::row_t         fwd_row;
  cfa_pkg::row_t         rd_row;
  cfa_pkg::row_t         old_row;
  cfa_pkg::row_t         new_row;
  logic                  wr_en;
  logic                  emit;

  cfa_ram #(
    .WIDTH($bits(cfa_pkg::row_t)),
    .DEPTH(cfa_pkg::MAX_GROUPS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_step.gi),
    .wr_data (new_row),
    .rd_en   (accept),
    .rd_addr (step.gi),
    .rd_data (rd_row)
  );

  always_comb begin
    if (s1_step.first_frame) begin
      old_row = '0;
    end else if (s1_fwd) begin
      old_row = fwd_row;
    end else begin
      old_row = rd_row;
    end
    for (int k = 0; k < cfa_pkg::LANES; k++) begin
      new_row[k] = cfa_pkg::add_word(old_row[k], cfa_pkg::lane_sample(s1_samples, k));
    end
  end

  assign advance = !s1_valid || !s1_step.last_frame || !sum_valid || !sum_stall;
  assign wr_en   = s1_valid && !s1_step.last_frame;
  assign emit    = s1_valid && s1_step.last_frame && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid <= accept;
      end
      if (emit) begin
        sum_valid <= 1'b1;
      end else if (!sum_stall) begin
        sum_valid <= 1'b0;
      end
    end
  end

  // load the stage, bypass the row being written back this cycle, capture sums
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_step    <= step;
      s1_samples <= samples;
      s1_fwd     <= wr_en && (s1_step.gi == step.gi);
      fwd_row    <= new_row;
    end
    if (emit) begin
      sums <= cfa_pkg::pack_sums(new_row, s1_step.last_group);
    end
  end

`ifndef ASSERT_OFF
  a_fwd_not_first: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_fwd) |-> !s1_step.first_frame)
    else $error("bypass used on first frame");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    emit |=> sum_valid)
    else $error("last-frame beat lost");

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_step)))
    else $error("held stage changed");
`endif

endmodule

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_GROUPS  = 1650;
  localparam int DRAIN_CYCLES   = 6;
  localparam int RUN_CAP        = 400;
  localparam int DEEP_GROUPS    = 320;

  class accumulator_board;
    logic [cfa_pkg::WORD_BITS-1:0] rows [cfa_pkg::MAX_GROUPS*cfa_pkg::LANES];
    int unsigned                   group_pos;
    int unsigned                   frame_pos;
    logic [cfa_pkg::GC_BITS-1:0]   group_reg;
    logic [cfa_pkg::FC_BITS-1:0]   frame_reg;
    cfa_pkg::sum_beat_t            pending[$];
    int                            mismatches;

    function new();
      group_pos  = 0;
      frame_pos  = 0;
      group_reg  = 1;
      frame_reg  = 1;
      mismatches = 0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      if (idx == cfa_pkg::REG_GROUP_COUNT) begin
        group_reg = value[cfa_pkg::GC_BITS-1:0];
      end else begin
        frame_reg = value[cfa_pkg::FC_BITS-1:0];
      end
    endfunction

    function void note_sample(cfa_pkg::sample_beat_t beat);
      logic [0:7][31:0]                       lane;
      logic [0:7][63:0]                       word;
      logic [cfa_pkg::WORD_BITS-1:0]          old;
      logic signed [cfa_pkg::SAMPLE_BITS-1:0] re_s;
      logic signed [cfa_pkg::SAMPLE_BITS-1:0] im_s;
      logic [cfa_pkg::SUM_BITS-1:0]           re_in;
      logic [cfa_pkg::SUM_BITS-1:0]           im_in;
      logic [cfa_pkg::SUM_BITS-1:0]           re;
      logic [cfa_pkg::SUM_BITS-1:0]           im;
      int unsigned                            groups;
      int unsigned                            frames;
      int unsigned                            gi;
      bit                                     first_frame;
      bit                                     last_frame;
      bit                                     last_group;
      lane = beat;
      groups = (group_reg == 0) ? 1 :
               (group_reg > cfa_pkg::MAX_GROUPS) ? cfa_pkg::MAX_GROUPS : group_reg;
      frames = (frame_reg == 0) ? 1 : frame_reg;
      gi = group_pos % cfa_pkg::MAX_GROUPS;
      first_frame = (frame_pos == 0);
      last_frame  = (frame_pos + 1 >= frames);
      last_group  = (gi + 1 >= groups);
      word = '0;
      for (int k = 0; k < cfa_pkg::LANES; k++) begin
        old   = first_frame ? '0 : rows[gi*cfa_pkg::LANES + k];
        re_s  = lane[k][2*cfa_pkg::SAMPLE_BITS-1:cfa_pkg::SAMPLE_BITS];
        im_s  = lane[k][cfa_pkg::SAMPLE_BITS-1:0];
        re_in = cfa_pkg::SUM_BITS'(re_s);
        im_in = cfa_pkg::SUM_BITS'(im_s);
        re    = old[cfa_pkg::WORD_BITS-1:cfa_pkg::SUM_BITS] + re_in;
        im    = old[cfa_pkg::SUM_BITS-1:0] + im_in;
        word[k] = 64'({re, im});
        if (!last_frame) begin
          rows[gi*cfa_pkg::LANES + k] = {re, im};
        end
      end
      if (last_frame) begin
        pending.push_back(cfa_pkg::sum_beat_t'({word, last_group}));
      end
      if (last_group) begin
        group_pos = 0;
        frame_pos = last_frame ? 0 : ((frame_pos + 1) & 16'hFFFF);
      end else begin
        group_pos = gi + 1;
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: %s", msg);
      end
    endfunction

    function void check_sum(cfa_pkg::sum_beat_t got);
      cfa_pkg::sum_beat_t want;
      logic [0:7][63:0]   got_w;
      logic [0:7][63:0]   want_w;
      logic               got_end;
      logic               want_end;
      if (pending.size() == 0) begin
        flag($sformatf("sum beat with nothing expected: %h", got));
        return;
      end
      want = pending.pop_front();
      {got_w, got_end}   = got;
      {want_w, want_end} = want;
      for (int k = 0; k < 8; k++) begin
        if (got_w[k] !== want_w[k]) begin
          flag($sformatf("sum_%0d expected %h got %h", k, want_w[k], got_w[k]));
        end
      end
      if (got_end !== want_end) begin
        flag($sformatf("frame_end expected %b got %b", want_end, got_end));
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  cfa_pkg::sample_beat_t samples = '0;
  logic                  sum_valid;
  logic                  sum_stall = 1'b0;
  cfa_pkg::sum_beat_t    sums;

  accumulator_board board = new();

  bit sender_steady = 1'b0;
  bit sink_steady   = 1'b0;
  bit hold_armed    = 1'b0;
  int stall_left    = 0;
  int idle_cycles   = 0;

  complex_frame_accumulator_core uut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic cfa_pkg::sample_beat_t random_group(int mode);
    logic [0:7][31:0] lane;
    logic [15:0]      corner[5] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF};
    for (int k = 0; k < 8; k++) begin
      case (mode)
        0: lane[k] = $urandom();
        1: lane[k] = {corner[$urandom_range(0, 4)], corner[$urandom_range(0, 4)]};
        default: lane[k] = {16'(int'($urandom_range(0, 8)) - 4),
                            16'(int'($urandom_range(0, 8)) - 4)};
      endcase
    end
    return cfa_pkg::sample_beat_t'(lane);
  endfunction

  task automatic send_group(input cfa_pkg::sample_beat_t beat);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    samples <= beat;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    board.note_sample(beat);
  endtask

  task automatic send_run(input int count, input int mode);
    for (int i = 0; i < count; i++) begin
      send_group(random_group(mode < 0 ? $urandom_range(0, 2) : mode));
    end
  endtask

  task automatic settle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int groups, input int frames);
    if ($urandom_range(0, 1)) begin
      write_register(cfa_pkg::REG_GROUP_COUNT, groups);
      write_register(cfa_pkg::REG_FRAME_COUNT, frames);
    end else begin
      write_register(cfa_pkg::REG_FRAME_COUNT, frames);
      write_register(cfa_pkg::REG_GROUP_COUNT, groups);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (sum_valid && !sum_stall) begin
        board.check_sum(sums);
        if ($urandom_range(0, 99) == 0) sink_steady = !sink_steady;
      end
      if (stall_left > 0) begin
        stall_left--;
        sum_stall <= 1'b1;
      end else if (hold_armed && sum_valid) begin
        // hold the sum side off long enough for the sample side to back up
        hold_armed = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        sum_stall <= 1'b1;
      end else begin
        stall_left = sink_steady ? 0 : pick_gap();
        sum_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((sample_valid && !sample_stall) || (sum_valid && !sum_stall) ||
          (psel && penable && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("complex_frame_accumulator_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    int gc;
    int fc;
    int n;
    int r;
    int mode;
    int sent;
    sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_group(cfa_pkg::sample_beat_t'({8{32'h00000000}}));
    send_group(cfa_pkg::sample_beat_t'({8{32'hFFFFFFFF}}));
    send_group(cfa_pkg::sample_beat_t'({8{32'h80008000}}));
    send_group(cfa_pkg::sample_beat_t'({8{32'h7FFF7FFF}}));
    send_group(cfa_pkg::sample_beat_t'({32'h7FFF8000, 32'h80007FFF, 32'h00010000,
                                        32'h0000FFFF, 32'hFFFF0001, 32'h00008000,
                                        32'h80000000, 32'h7FFF0000}));
    settle();
    sent += 5;

    configure(0, 0);
    send_run(2, 0);
    settle();
    sent += 2;

    // shrink the frame count mid-run: the current frame becomes the last
    configure(2, 16'hFFFF);
    send_run(6, -1);
    settle();
    write_register(cfa_pkg::REG_FRAME_COUNT, 3);
    send_run(2, 1);
    settle();
    sent += 8;

    // shrink the group count mid-frame: the current group becomes the last
    configure(8191, 1);
    send_run(3, 0);
    settle();
    write_register(cfa_pkg::REG_GROUP_COUNT, 2);
    send_run(1, 0);
    settle();
    sent += 4;

    configure(DEEP_GROUPS, 2);
    send_run(2 * DEEP_GROUPS, -1);
    settle();
    sent += 2 * DEEP_GROUPS;

    hold_armed = 1'b1;
    configure(200, 1);
    send_run(200, 0);
    settle();
    sent += 200;

    while (sent < RANDOM_GROUPS) begin
      r = $urandom_range(0, 99);
      gc = (r < 8)  ? 0 :
           (r < 55) ? $urandom_range(1, 4) :
           (r < 85) ? $urandom_range(5, 16) :
           (r < 96) ? $urandom_range(17, 64) : $urandom_range(65, 256);
      r = $urandom_range(0, 99);
      fc = (r < 8)  ? 0 :
           (r < 45) ? 1 :
           (r < 85) ? $urandom_range(2, 4) : $urandom_range(5, 12);
      n = (gc == 0 ? 1 : gc) * (fc == 0 ? 1 : fc);
      if (n > RUN_CAP) begin
        fc = 1;
        n = gc;
      end
      r = $urandom_range(0, 9);
      mode = (r < 5) ? 0 : (r < 7) ? 1 : (r < 8) ? 2 : -1;
      sender_steady = ($urandom_range(0, 3) == 0);
      configure(gc, fc);
      send_run(n, mode);
      settle();
      sent += n;
    end

    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("complex_frame_accumulator_core verification clean");
    end else begin
      $display("complex_frame_accumulator_core verification failed");
    end
    $finish;
  end

endmodule
